/* rtl/lpfd_pkg.sv */
// Shared types and constants for the length-prefix frame decoder.
package lpfd_pkg;

   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 32;
   localparam int HDR_W    = 24;
   localparam int HCOUNT_W = 2;
   localparam int KIND_W   = 2;

   localparam logic [LEN_W-1:0]    MAX_FRAME_RESET = 32'd65536;
   localparam logic [HCOUNT_W-1:0] HDR_LAST_COUNT  = 2'd3;

   typedef enum logic [0:0] {
      CMD_DATA  = 1'b0,
      CMD_CLEAR = 1'b1
   } command_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_PAYLOAD    = 2'd0,
      KIND_BAD_LENGTH = 2'd1,
      KIND_DROPPED    = 2'd2
   } result_kind_type;

   typedef struct packed {
      logic              command;
      logic [BYTE_W-1:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic [KIND_W-1:0] result_kind;
      logic [BYTE_W-1:0] payload_byte;
      logic              frame_first;
      logic              frame_last;
      logic              error_flag;
   } rsp_item_type;

endpackage

/* rtl/lpfd_if.sv */
// Channel interfaces for the request, response and register write ports.
interface lpfd_req_if;
   logic                        valid;
   logic                        ready;
   logic                        command;
   logic [lpfd_pkg::BYTE_W-1:0] data_byte;

   modport source (output valid, output command, output data_byte, input ready);
   modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface lpfd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lpfd_pkg::KIND_W-1:0] result_kind;
   logic [lpfd_pkg::BYTE_W-1:0] payload_byte;
   logic                        frame_first;
   logic                        frame_last;
   logic                        error_flag;

   modport source (output valid, output result_kind, output payload_byte,
                   output frame_first, output frame_last, output error_flag,
                   input ready);
   modport sink   (input valid, input result_kind, input payload_byte,
                   input frame_first, input frame_last, input error_flag,
                   output ready);
endinterface

interface lpfd_csr_if;
   logic                       valid;
   logic                       ready;
   logic [lpfd_pkg::LEN_W-1:0] max_frame_size;

   modport source (output valid, output max_frame_size, input ready);
   modport sink   (input valid, input max_frame_size, output ready);
endinterface

/* rtl/lpfd_parser.sv */
// Input register, parser state and the per-byte decode logic.
module lpfd_parser (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  lpfd_pkg::req_item_type     in_item,
   input  logic [lpfd_pkg::LEN_W-1:0] max_frame_size,
   input  logic                       res_ready,
   output logic                       res_valid,
   output lpfd_pkg::rsp_item_type     res_item
);
   import lpfd_pkg::*;

   logic                  item_valid_ff, item_valid_in;
   req_item_type          item_ff;
   logic [HDR_W-1:0]      header_ff, header_in;
   logic [HCOUNT_W-1:0]   hcount_ff, hcount_in;
   logic [LEN_W-1:0]      remain_ff, remain_in;
   logic                  in_payload_ff, in_payload_in;
   logic                  first_ff, first_in;
   logic                  error_ff, error_in;
   logic                  process;
   logic                  has_result;
   logic                  last_byte;
   logic [LEN_W-1:0]      length;
   logic                  bad_length;

   // The held item is decoded once the result register can take its result.
   assign process  = item_valid_ff && res_ready;
   assign in_ready = !item_valid_ff || res_ready;

   assign length     = {header_ff, item_ff.data_byte};
   assign bad_length = (length == '0) || (length > max_frame_size);
   assign last_byte  = (remain_ff <= LEN_W'(1));

   always_comb begin
      item_valid_in = item_valid_ff;
      if (in_ready) begin
         item_valid_in = in_valid;
      end
   end

   always_comb begin
      header_in     = header_ff;
      hcount_in     = hcount_ff;
      remain_in     = remain_ff;
      in_payload_in = in_payload_ff;
      first_in      = first_ff;
      error_in      = error_ff;
      has_result    = 1'b0;
      res_item      = '0;
      if (process) begin
         if (item_ff.command == CMD_CLEAR) begin
            header_in     = '0;
            hcount_in     = '0;
            remain_in     = '0;
            in_payload_in = 1'b0;
            first_in      = 1'b0;
            error_in      = 1'b0;
         end else if (error_ff) begin
            has_result           = 1'b1;
            res_item.result_kind = KIND_DROPPED;
            res_item.error_flag  = 1'b1;
         end else if (in_payload_ff) begin
            has_result            = 1'b1;
            first_in              = 1'b0;
            remain_in             = last_byte ? '0 : remain_ff - LEN_W'(1);
            in_payload_in         = !last_byte;
            res_item.result_kind  = KIND_PAYLOAD;
            res_item.payload_byte = item_ff.data_byte;
            res_item.frame_first  = first_ff;
            res_item.frame_last   = last_byte;
         end else if (hcount_ff != HDR_LAST_COUNT) begin
            header_in = {header_ff[HDR_W-BYTE_W-1:0], item_ff.data_byte};
            hcount_in = hcount_ff + HCOUNT_W'(1);
         end else begin
            header_in = '0;
            hcount_in = '0;
            if (bad_length) begin
               has_result           = 1'b1;
               error_in             = 1'b1;
               res_item.result_kind = KIND_BAD_LENGTH;
               res_item.error_flag  = 1'b1;
            end else begin
               remain_in     = length;
               in_payload_in = 1'b1;
               first_in      = 1'b1;
            end
         end
      end
   end

   assign res_valid = process && has_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         header_ff     <= '0;
         hcount_ff     <= '0;
         remain_ff     <= '0;
         in_payload_ff <= 1'b0;
         first_ff      <= 1'b0;
         error_ff      <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         header_ff     <= header_in;
         hcount_ff     <= hcount_in;
         remain_ff     <= remain_in;
         in_payload_ff <= in_payload_in;
         first_ff      <= first_in;
         error_ff      <= error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

endmodule

/* rtl/lpfd_out_stage.sv */
// Result register that holds one item until the consumer takes it.
module lpfd_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   res_valid,
   output logic                   res_ready,
   input  lpfd_pkg::rsp_item_type res_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output lpfd_pkg::rsp_item_type out_item
);
   import lpfd_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   assign res_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (res_ready) begin
         valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         item_ff <= res_item;
      end
   end

endmodule

/* rtl/length_prefix_frame_decoder.sv */
// Top level: an item can be accepted in every cycle unless stalled; any result it gives is registered.
// Path: an accepted item goes through the input register and then the result register.
// Throughput: one item per cycle unless stalled; byte counter, length compare sit between the registers.
// A waiting result stalls the parser, so the input stalls once the input register holds an item.
// Reset is synchronous: it clears the parser state and the error flag and sets max_frame_size to 65536.
module length_prefix_frame_decoder (
   input  logic       clock,
   input  logic       reset,
   lpfd_req_if.sink   req_chan,
   lpfd_rsp_if.source rsp_chan,
   lpfd_csr_if.sink   csr_chan
);
   import lpfd_pkg::*;

   logic [LEN_W-1:0] max_size_ff, max_size_in;
   req_item_type     in_item;
   rsp_item_type     res_item;
   rsp_item_type     out_item;
   logic             res_valid;
   logic             res_ready;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      max_size_in = max_size_ff;
      if (csr_chan.valid) begin
         max_size_in = csr_chan.max_frame_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff <= MAX_FRAME_RESET;
      end else begin
         max_size_ff <= max_size_in;
      end
   end

   assign in_item.command   = req_chan.command;
   assign in_item.data_byte = req_chan.data_byte;

   lpfd_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_chan.valid),
      .in_ready       (req_chan.ready),
      .in_item        (in_item),
      .max_frame_size (max_size_ff),
      .res_ready      (res_ready),
      .res_valid      (res_valid),
      .res_item       (res_item)
   );

   lpfd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_item  (res_item),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_item  (out_item)
   );

   assign rsp_chan.result_kind  = out_item.result_kind;
   assign rsp_chan.payload_byte = out_item.payload_byte;
   assign rsp_chan.frame_first  = out_item.frame_first;
   assign rsp_chan.frame_last   = out_item.frame_last;
   assign rsp_chan.error_flag   = out_item.error_flag;

endmodule
